>>> src/slipdf_pkg.sv
package slipdf_pkg;

  // Framing bytes of the serial line protocol.
  localparam logic [7:0] FRAME_BYTE = 8'hC0;
  localparam logic [7:0] ESC_BYTE   = 8'hDB;
  localparam logic [7:0] ESC_FRAME  = 8'hDC;
  localparam logic [7:0] ESC_ESC    = 8'hDD;

  localparam int unsigned HEADER_BYTES = 8;
  localparam logic [15:0] HDR_LAST_IDX = 16'(HEADER_BYTES - 1);

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4096;

  // Result kinds, carried on the result tuser.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_FAULT   = 2'd3;

  // Fault codes.
  localparam logic [1:0] FLT_NONE      = 2'd0;
  localparam logic [1:0] FLT_NO_FRAME  = 2'd1;
  localparam logic [1:0] FLT_BAD_ESC   = 2'd2;
  localparam logic [1:0] FLT_TOO_LARGE = 2'd3;

  localparam int unsigned OUT_DATA_W = 96;

  typedef enum logic [4:0] {
    PH_OPEN    = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_CLOSE   = 5'b01000,
    PH_HALT    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [1:0]  fault_code;
    logic [7:0]  direction;
    logic [7:0]  opcode;
    logic [15:0] payload_size;
    logic [31:0] checksum;
  } result_t;

endpackage

>>> src/slip_packet_deframer.sv
// SLIP packet deframer.
// Raw bytes from the serial link arrive on the in_ stream, one word per byte.
// Each packet is a frame byte 0xC0, an 8-byte header (direction, command,
// little-endian size, little-endian checksum), size payload bytes and a
// closing 0xC0. Escape pairs are decoded; a raw 0xC0 inside a packet is data.
// Every decoded header or payload byte leaves on the out_ stream as one word
// tagged by out_tuser, and the closing byte leaves a packet-end word that
// carries the header fields. A missing frame byte, a bad escape pair or a
// size above cfg max_payload gives one fault word, after which the block
// ignores all input until reset.
// Results are registered in the output register, or in the skid register
// while it stalls. Throughput is one byte per cycle while in_tready is high;
// the decode is a single register-to-register step on the phase register.
// The result side has an output register and a one-word skid register, so
// in_tready only drops when both are full, which takes a stall of out_tready
// with a result pending and another result arriving behind it. Nothing is
// dropped while the receiver stalls.
// A synchronous low rst_n clears the state and valid flags, sets max_payload
// to 4096. cfg_wr_en writes max_payload at the edge; write it only when idle.
module slip_packet_deframer
  import slipdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data,  // max_payload
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,     // rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // From bit 0 up: data_byte[7:0], byte_index[23:8], fault_code[25:24],
  // direction[33:26], opcode[41:34], payload_size[57:42], checksum[89:58],
  // zero fill [95:90].
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser     // kind
);

  // Decoder state.
  phase_t      phase_r,   phase_nxt;
  logic        esc_r,     esc_nxt;
  logic [15:0] pos_r,     pos_nxt;
  logic [7:0]  hdr_dir_r, hdr_dir_nxt;
  logic [7:0]  hdr_op_r,  hdr_op_nxt;
  logic [15:0] hdr_size_r, hdr_size_nxt;
  logic [31:0] hdr_csum_r, hdr_csum_nxt;
  logic [15:0] max_payload_r;

  // Result buffering: output register plus one skid entry.
  result_t     main_r, skid_r;
  logic        main_valid_r, skid_valid_r;

  logic        in_fire;
  logic        res_v;
  result_t     res;
  logic [7:0]  dec_byte;
  logic        take;
  logic [16:0] pos_inc;

  assign in_tready = ~skid_valid_r;
  assign in_fire   = in_tvalid & in_tready;

  always_comb begin
    phase_nxt    = phase_r;
    esc_nxt      = esc_r;
    pos_nxt      = pos_r;
    hdr_dir_nxt  = hdr_dir_r;
    hdr_op_nxt   = hdr_op_r;
    hdr_size_nxt = hdr_size_r;
    hdr_csum_nxt = hdr_csum_r;
    res_v        = 1'b0;
    res          = '0;
    dec_byte     = in_tdata;
    take         = 1'b0;
    pos_inc      = {1'b0, pos_r} + 17'd1;

    case (phase_r)
      PH_OPEN: begin
        if (in_tdata != FRAME_BYTE) begin
          res_v          = 1'b1;
          res.kind       = KIND_FAULT;
          res.fault_code = FLT_NO_FRAME;
          phase_nxt      = PH_HALT;
          esc_nxt        = 1'b0;
        end else begin
          phase_nxt    = PH_HEADER;
          pos_nxt      = '0;
          esc_nxt      = 1'b0;
          hdr_dir_nxt  = '0;
          hdr_op_nxt   = '0;
          hdr_size_nxt = '0;
          hdr_csum_nxt = '0;
        end
      end

      PH_HEADER, PH_PAYLOAD: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          if (in_tdata == ESC_FRAME) begin
            dec_byte = FRAME_BYTE;
            take     = 1'b1;
          end else if (in_tdata == ESC_ESC) begin
            dec_byte = ESC_BYTE;
            take     = 1'b1;
          end else begin
            res_v          = 1'b1;
            res.kind       = KIND_FAULT;
            res.fault_code = FLT_BAD_ESC;
            phase_nxt      = PH_HALT;
          end
        end else if (in_tdata == ESC_BYTE) begin
          esc_nxt = 1'b1;
        end else begin
          take = 1'b1;
        end

        if (take) begin
          res_v          = 1'b1;
          res.data_byte  = dec_byte;
          res.byte_index = pos_r;
          pos_nxt        = pos_inc[15:0];
          if (phase_r == PH_HEADER) begin
            res.kind = KIND_HEADER;
            case (pos_r[2:0])
              3'd0:    hdr_dir_nxt = dec_byte;
              3'd1:    hdr_op_nxt = dec_byte;
              3'd2:    hdr_size_nxt[7:0] = dec_byte;
              3'd3:    hdr_size_nxt[15:8] = dec_byte;
              3'd4:    hdr_csum_nxt[7:0] = dec_byte;
              3'd5:    hdr_csum_nxt[15:8] = dec_byte;
              3'd6:    hdr_csum_nxt[23:16] = dec_byte;
              default: hdr_csum_nxt[31:24] = dec_byte;
            endcase
            if (pos_r == HDR_LAST_IDX) begin
              // The size bytes are already stored when the last byte arrives.
              if (hdr_size_r > max_payload_r) begin
                res            = '0;
                res.kind       = KIND_FAULT;
                res.fault_code = FLT_TOO_LARGE;
                phase_nxt      = PH_HALT;
                esc_nxt        = 1'b0;
              end else begin
                pos_nxt   = '0;
                phase_nxt = (hdr_size_r == '0) ? PH_CLOSE : PH_PAYLOAD;
              end
            end
          end else begin
            res.kind = KIND_PAYLOAD;
            if (pos_inc >= {1'b0, hdr_size_r}) begin
              pos_nxt   = '0;
              phase_nxt = PH_CLOSE;
            end
          end
        end
      end

      PH_CLOSE: begin
        res_v   = 1'b1;
        esc_nxt = 1'b0;
        if (in_tdata != FRAME_BYTE) begin
          res.kind       = KIND_FAULT;
          res.fault_code = FLT_NO_FRAME;
          phase_nxt      = PH_HALT;
        end else begin
          res.kind         = KIND_END;
          res.direction    = hdr_dir_r;
          res.opcode       = hdr_op_r;
          res.payload_size = hdr_size_r;
          res.checksum     = hdr_csum_r;
          phase_nxt        = PH_OPEN;
          pos_nxt          = '0;
        end
      end

      default: begin
        // Halted after a fault: input is consumed and dropped.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_OPEN;
      esc_r         <= 1'b0;
      pos_r         <= '0;
      hdr_dir_r     <= '0;
      hdr_op_r      <= '0;
      hdr_size_r    <= '0;
      hdr_csum_r    <= '0;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else begin
      if (cfg_wr_en) begin
        max_payload_r <= cfg_wr_data;
      end
      if (in_fire) begin
        phase_r    <= phase_nxt;
        esc_r      <= esc_nxt;
        pos_r      <= pos_nxt;
        hdr_dir_r  <= hdr_dir_nxt;
        hdr_op_r   <= hdr_op_nxt;
        hdr_size_r <= hdr_size_nxt;
        hdr_csum_r <= hdr_csum_nxt;
      end
    end
  end

  // When the output register drains, the skid entry moves up first; a new
  // result can only arrive while the skid entry is empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || out_tready) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= in_fire & res_v;
      end
    end else if (in_fire && res_v) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || out_tready) begin
      main_r <= skid_valid_r ? skid_r : res;
    end else if (in_fire && res_v) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = main_valid_r;
  assign out_tuser  = main_r.kind;
  assign out_tdata  = {6'd0, main_r.checksum, main_r.payload_size, main_r.opcode,
                       main_r.direction, main_r.fault_code, main_r.byte_index,
                       main_r.data_byte};

endmodule

>>> src/slipdf_checker.sv
module slipdf_checker
  import slipdf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Input back-pressure only appears behind a pending result.
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

  // A fault is the last word until reset.
  a_fault_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == KIND_FAULT |=> !out_tvalid)
    else $error("result after a fault word");

  // Fault words carry a nonzero code, other words none.
  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == KIND_FAULT) == (out_tdata[25:24] != FLT_NONE)))
    else $error("fault code does not match the word kind");

endmodule

bind slip_packet_deframer slipdf_checker u_slipdf_checker (.*);

>>> tb/tb_top.sv
module tb_top;
  import slipdf_pkg::*;

  // How a 0xC0 data byte is put on the line: left raw, sent as an escape
  // pair, or chosen at random per byte.
  localparam int FRAME_RAW     = 0;
  localparam int FRAME_ESCAPED = 1;
  localparam int FRAME_EITHER  = 2;

  // Cycles with no word accepted on either side before the run is called hung.
  localparam int QUIET_LIMIT = 1000;

  // Cycles to let pass after the last result before touching max_payload.
  // An opening byte or an escape byte leaves no result, so the block may
  // still be digesting a word when the result queue runs dry.
  localparam int SETTLE_CYCLES = 4;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [15:0]           cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  // Raw line bytes waiting for the driver, and decoded words that the
  // block still owes us, oldest first.
  logic [7:0] raw_bytes [$];
  result_t    expected_words [$];
  result_t    oldest;

  int  queued_bytes = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  // While set, neither side inserts idle cycles.
  bit  no_gaps = 1'b0;

  // Our own copy of the deframer state and of max_payload.
  phase_t      rx_phase;
  logic        esc_seen;
  logic [15:0] pos;
  logic [15:0] limit;
  logic [7:0]  hdr_dir;
  logic [7:0]  hdr_op;
  logic [15:0] hdr_len;
  logic [31:0] hdr_sum;

  slip_packet_deframer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Deframer prediction
  // ---------------------------------------------------------------------

  task automatic clear_model();
    rx_phase = PH_OPEN;
    esc_seen = 1'b0;
    pos      = '0;
    limit    = MAX_PAYLOAD_RST;
    hdr_dir  = '0;
    hdr_op   = '0;
    hdr_len  = '0;
    hdr_sum  = '0;
  endtask

  // A fault word carries only its code; the block then goes deaf until reset.
  task automatic raise_fault(input logic [1:0] code);
    result_t r;
    r = '0;
    r.kind = KIND_FAULT;
    r.fault_code = code;
    expected_words.push_back(r);
    rx_phase = PH_HALT;
    esc_seen = 1'b0;
  endtask

  task automatic owe_data_word(input logic [1:0] kind, input logic [7:0] b,
                               input logic [15:0] idx);
    result_t r;
    r = '0;
    r.kind = kind;
    r.data_byte = b;
    r.byte_index = idx;
    expected_words.push_back(r);
  endtask

  // Advances the model by one accepted line byte and queues the word it owes.
  task automatic deframe_byte(input logic [7:0] rx);
    logic [7:0]  b;
    logic [15:0] idx;
    result_t     r;
    b = rx;
    case (rx_phase)
      PH_OPEN: begin
        if (b != FRAME_BYTE) begin
          raise_fault(FLT_NO_FRAME);
        end else begin
          rx_phase = PH_HEADER;
          pos      = '0;
          esc_seen = 1'b0;
          hdr_dir  = '0;
          hdr_op   = '0;
          hdr_len  = '0;
          hdr_sum  = '0;
        end
      end
      PH_HEADER, PH_PAYLOAD: begin
        if (esc_seen) begin
          esc_seen = 1'b0;
          if (b == ESC_FRAME) begin
            b = FRAME_BYTE;
          end else if (b == ESC_ESC) begin
            b = ESC_BYTE;
          end else begin
            raise_fault(FLT_BAD_ESC);
            return;
          end
        end else if (b == ESC_BYTE) begin
          esc_seen = 1'b1;
          return;
        end
        idx = pos;
        pos = idx + 16'd1;
        if (rx_phase == PH_HEADER) begin
          // Size and checksum are little endian, so each new byte enters
          // at the top and the earlier ones slide down.
          case (idx)
            16'd0:        hdr_dir = b;
            16'd1:        hdr_op = b;
            16'd2, 16'd3: hdr_len = {b, hdr_len[15:8]};
            default:      hdr_sum = {b, hdr_sum[31:8]};
          endcase
          if (idx == HDR_LAST_IDX) begin
            // An oversize header replaces its last byte's word with a fault.
            if (hdr_len > limit) begin
              raise_fault(FLT_TOO_LARGE);
              return;
            end
            pos = '0;
            rx_phase = (hdr_len == 16'd0) ? PH_CLOSE : PH_PAYLOAD;
          end
          owe_data_word(KIND_HEADER, b, idx);
        end else begin
          if (pos >= hdr_len) begin
            pos = '0;
            rx_phase = PH_CLOSE;
          end
          owe_data_word(KIND_PAYLOAD, b, idx);
        end
      end
      PH_CLOSE: begin
        if (b != FRAME_BYTE) begin
          raise_fault(FLT_NO_FRAME);
        end else begin
          r = '0;
          r.kind = KIND_END;
          r.direction = hdr_dir;
          r.opcode = hdr_op;
          r.payload_size = hdr_len;
          r.checksum = hdr_sum;
          expected_words.push_back(r);
          rx_phase = PH_OPEN;
          pos = '0;
          esc_seen = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Driver: one line byte per word, with random gaps unless no_gaps is set.
  // The model is stepped at the edge where the word is taken.
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      clear_model();
    end else begin
      if (in_tvalid && in_tready) begin
        deframe_byte(in_tdata);
      end
      if (!in_tvalid || in_tready) begin
        if (raw_bytes.size() != 0 && (no_gaps || $urandom_range(99) >= 30)) begin
          in_tvalid <= 1'b1;
          in_tdata <= raw_bytes.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every word taken on the result side is held against the
  // oldest word still owed, field by field.
  // ---------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing owed: kind %0d, data 0x%0h",
                 out_tuser, out_tdata);
          mismatches++;
        end else begin
          oldest = expected_words.pop_front();
          check_field("kind", 32'(oldest.kind), 32'(out_tuser));
          check_field("data_byte", 32'(oldest.data_byte), 32'(out_tdata[7:0]));
          check_field("byte_index", 32'(oldest.byte_index), 32'(out_tdata[23:8]));
          check_field("fault_code", 32'(oldest.fault_code), 32'(out_tdata[25:24]));
          check_field("direction", 32'(oldest.direction), 32'(out_tdata[33:26]));
          check_field("opcode", 32'(oldest.opcode), 32'(out_tdata[41:34]));
          check_field("payload_size", 32'(oldest.payload_size),
                      32'(out_tdata[57:42]));
          check_field("checksum", oldest.checksum, out_tdata[89:58]);
        end
      end
      out_tready <= no_gaps || ($urandom_range(99) >= 30);
    end
  end

  // Watchdog: a run that stops moving words on both sides is hung.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic push_raw(input logic [7:0] b);
    raw_bytes.push_back(b);
    queued_bytes++;
  endtask

  // Puts one data byte on the line. 0xDB must always be escaped; 0xC0 may
  // travel raw since a raw frame byte inside a packet counts as data.
  task automatic push_coded(input logic [7:0] b, input int frame_style);
    bit escape_it;
    escape_it = (frame_style == FRAME_EITHER) ? bit'($urandom_range(1))
                                              : (frame_style == FRAME_ESCAPED);
    if (b == ESC_BYTE) begin
      push_raw(ESC_BYTE);
      push_raw(ESC_ESC);
    end else if (b == FRAME_BYTE && escape_it) begin
      push_raw(ESC_BYTE);
      push_raw(ESC_FRAME);
    end else begin
      push_raw(b);
    end
  endtask

  // Random data byte, leaning toward the values the framing cares about.
  function automatic logic [7:0] pick_byte();
    logic [7:0] special [6] = '{8'h00, 8'hFF, FRAME_BYTE, ESC_BYTE, ESC_FRAME, ESC_ESC};
    if ($urandom_range(3) == 0) return special[$urandom_range(5)];
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] byte_other_than(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] v;
    do v = 8'($urandom); while (v == a || v == b);
    return v;
  endfunction

  task automatic queue_header(input logic [7:0] dir, input logic [7:0] op,
                              input logic [15:0] len, input logic [31:0] sum,
                              input int frame_style);
    logic [63:0] head;
    head = {sum, len, op, dir};
    for (int i = 0; i < 8; i++) push_coded(head[8*i +: 8], frame_style);
  endtask

  task automatic queue_packet(input logic [7:0] dir, input logic [7:0] op,
                              input logic [15:0] len, input logic [31:0] sum,
                              input int frame_style, input logic [7:0] closer);
    push_raw(FRAME_BYTE);
    queue_header(dir, op, len, sum, frame_style);
    for (int i = 0; i < int'(len); i++) push_coded(pick_byte(), frame_style);
    push_raw(closer);
  endtask

  task automatic queue_random_packet(input logic [15:0] len);
    queue_packet(pick_byte(), pick_byte(), len, $urandom, FRAME_EITHER, FRAME_BYTE);
  endtask

  // Holds the sender until every owed word is in, then lets the block settle.
  // The queues are looked at on the falling edge, when the driver and the
  // monitor are done with the rising edge before it.
  task automatic wait_drained();
    do @(negedge clk);
    while (raw_bytes.size() != 0 || in_tvalid || expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit = v;
  endtask

  // ---------------------------------------------------------------------
  // Test sequence. Since any fault halts the block until reset and reset
  // happens only once, all packets are well formed and a single fault of
  // a randomly chosen kind closes the run, followed by bytes that must be
  // ignored.
  // ---------------------------------------------------------------------

  initial begin
    logic [1:0]  fault_pick;
    logic [15:0] len;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: widest limit, an empty packet with every header byte type
    // including a raw 0xC0 and an escaped 0xDB, then a short payload packet
    // whose 0xC0 bytes go out as escape pairs.
    write_max_payload(16'hFFFF);
    queue_packet(8'h00, 8'hFF, 16'd0, {ESC_BYTE, FRAME_BYTE, ESC_ESC, ESC_FRAME},
                 FRAME_RAW, FRAME_BYTE);
    queue_packet(FRAME_BYTE, ESC_BYTE, 16'd2, 32'hFFFF_0000, FRAME_ESCAPED, FRAME_BYTE);
    wait_drained();

    // Zero limit: only empty packets are legal.
    write_max_payload(16'd0);
    repeat (4) queue_random_packet(16'd0);
    wait_drained();

    // Small limit, both sides running flat out with no gaps.
    write_max_payload(16'($urandom_range(1, 40)));
    no_gaps = 1'b1;
    while (queued_bytes < 250) queue_random_packet(16'($urandom_range(0, int'(limit))));
    wait_drained();
    no_gaps = 1'b0;

    // Moderate limit with random gaps: one long payload, then short ones.
    write_max_payload(16'($urandom_range(300, 4096)));
    queue_random_packet(16'($urandom_range(200, 300)));
    while (queued_bytes < 540) queue_random_packet(16'($urandom_range(0, 24)));
    wait_drained();

    fault_pick = 2'($urandom_range(1, 3));
    case (fault_pick)
      FLT_NO_FRAME: begin
        if ($urandom_range(1)) begin
          // Missing opening byte.
          push_raw(byte_other_than(FRAME_BYTE, FRAME_BYTE));
        end else begin
          // Missing closing byte after a complete payload.
          queue_packet(pick_byte(), pick_byte(), 16'($urandom_range(0, 8)), $urandom,
                       FRAME_EITHER, byte_other_than(FRAME_BYTE, FRAME_BYTE));
        end
      end
      FLT_BAD_ESC: begin
        push_raw(FRAME_BYTE);
        repeat ($urandom_range(0, 7)) push_coded(pick_byte(), FRAME_EITHER);
        push_raw(ESC_BYTE);
        push_raw(byte_other_than(ESC_FRAME, ESC_ESC));
      end
      default: begin
        // Oversize header against a fresh random limit; the payload that
        // would follow is replaced by noise below.
        write_max_payload(16'($urandom_range(0, 65534)));
        len = 16'($urandom_range(int'(limit) + 1, 65535));
        push_raw(FRAME_BYTE);
        queue_header(pick_byte(), pick_byte(), len, $urandom, FRAME_EITHER);
      end
    endcase
    repeat (10) push_raw(8'($urandom));
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
